/* src/rlbc_pkg.sv */
// types, codes and helper functions for the rgb led mode and blink controller
// no dependencies; imported by every module of the block
package rlbc_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ENABLE = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_BLINK  = 3'd4,
    OP_EVENT  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    COL_RED     = 3'd0,
    COL_GREEN   = 3'd1,
    COL_BLUE    = 3'd2,
    COL_YELLOW  = 3'd3,
    COL_MAGENTA = 3'd4,
    COL_CYAN    = 3'd5,
    COL_ALL     = 3'd6
  } color_t;

  typedef enum logic [1:0] {
    LM_OFF   = 2'd0,
    LM_ON    = 2'd1,
    LM_BLINK = 2'd2,
    LM_EVENT = 2'd3
  } led_mode_t;

  typedef enum logic [3:0] {
    EV_IDLE = 4'b0001,
    EV_DARK = 4'b0010,
    EV_ON   = 4'b0100,
    EV_OFF  = 4'b1000
  } ev_phase_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  color;
    logic [31:0] interval;
    logic [7:0]  count;
    logic        enable_value;
  } cmd_t;

  typedef struct packed {
    logic       red_pin;
    logic       green_pin;
    logic       blue_pin;
    logic [1:0] current_mode;
  } res_t;

  typedef struct packed {
    logic [2:0]  pins;
    logic        enabled;
    led_mode_t   led_mode;
    logic [2:0]  active_color;
    logic [31:0] blink_interval;
    logic [31:0] tsc;
    logic [2:0]  saved_pins;
    led_mode_t   saved_mode;
    logic [15:0] ev_timer;
    logic [7:0]  blinks_left;
    ev_phase_t   ev_phase;
    logic [2:0]  ev_color;
  } state_t;

  // pin mask of a colour code, unused code selects nothing
  function automatic logic [2:0] color_mask(input logic [2:0] color);
    logic [2:0] mask;
    case (color_t'(color))
      COL_RED:     mask = 3'b001;
      COL_GREEN:   mask = 3'b010;
      COL_BLUE:    mask = 3'b100;
      COL_YELLOW:  mask = 3'b011;
      COL_MAGENTA: mask = 3'b101;
      COL_CYAN:    mask = 3'b110;
      COL_ALL:     mask = 3'b111;
      default:     mask = 3'b000;
    endcase
    return mask;
  endfunction

  // pins after driving the masked pins to a level, gated by the enable
  function automatic logic [2:0] drive_pins(input logic level, input logic enabled,
                                            input logic [2:0] pins, input logic [2:0] mask);
    logic [2:0] result;
    if (level && enabled) begin
      result = pins | mask;
    end else begin
      result = pins & ~mask;
    end
    return result;
  endfunction

endpackage

/* src/rgb_led_mode_blink_controller_core.sv */
// top level of the rgb led mode and blink controller: state, config and result buffer
// depends on rlbc_pkg, rlbc_step and rlbc_out_buf
//
// Takes one command or tick beat per clock cycle and returns one result beat for each,
// the pin levels and mode right after that beat, held in the result buffer. All state
// is updated by a single pass of logic in the accepting cycle, so back-to-back beats
// need no bubbles; a two-entry result buffer stalls the input only when both entries
// hold results not yet taken. phase_ticks is written through the config port, which is
// always ready and should only be written while the block is idle.
module rgb_led_mode_blink_controller_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  rlbc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output rlbc_pkg::res_t res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);
  import rlbc_pkg::*;

  state_t      st;
  state_t      st_next;
  res_t        step_res;
  logic [15:0] phase_ticks;
  logic        cmd_take;
  logic        buf_full;

  assign cfg_ready = 1'b1;
  assign cmd_stall = buf_full;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pins           <= 3'b000;
      st.enabled        <= 1'b0;
      st.led_mode       <= LM_OFF;
      st.active_color   <= 3'd0;
      st.blink_interval <= '0;
      st.tsc            <= '0;
      st.saved_pins     <= 3'b000;
      st.saved_mode     <= LM_OFF;
      st.ev_timer       <= '0;
      st.blinks_left    <= '0;
      st.ev_phase       <= EV_IDLE;
      st.ev_color       <= 3'd0;
    end else if (cmd_take) begin
      st <= st_next;
    end
  end

  rlbc_step u_step (
    .st          (st),
    .cmd         (cmd),
    .phase_ticks (phase_ticks),
    .st_next     (st_next),
    .res         (step_res)
  );

  rlbc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_take),
    .push_data (step_res),
    .full      (buf_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* src/rlbc_step.sv */
// next-state and result logic for one command or tick beat
// depends on rlbc_pkg
module rlbc_step (
  input  rlbc_pkg::state_t st,
  input  rlbc_pkg::cmd_t   cmd,
  input  logic [15:0]      phase_ticks,
  output rlbc_pkg::state_t st_next,
  output rlbc_pkg::res_t   res
);
  import rlbc_pkg::*;

  logic [2:0]  amask;
  logic [2:0]  emask;
  logic [2:0]  cmask;
  logic [31:0] tsc_inc;
  logic [15:0] timer_inc;
  logic [7:0]  blinks_dec;
  logic        lit;
  logic        do_restore;
  logic        do_light;

  assign amask      = color_mask(st.active_color);
  assign emask      = color_mask(st.ev_color);
  assign cmask      = color_mask(cmd.color);
  assign tsc_inc    = (st.tsc == '1) ? st.tsc : st.tsc + 32'd1;
  assign timer_inc  = st.ev_timer + 16'd1;
  assign blinks_dec = st.blinks_left - 8'd1;
  assign lit        = (st.pins & amask) != 3'b000;

  always_comb begin
    st_next    = st;
    do_restore = 1'b0;
    do_light   = 1'b0;
    case (op_t'(cmd.mode))
      OP_TICK: begin
        st_next.tsc = tsc_inc;
        if (st.ev_phase != EV_IDLE) begin
          if (timer_inc < phase_ticks) begin
            st_next.ev_timer = timer_inc;
          end else begin
            st_next.ev_timer = '0;
            case (st.ev_phase)
              EV_DARK: begin
                do_restore = (st.blinks_left == 8'd0);
                do_light   = (st.blinks_left != 8'd0);
              end
              EV_ON: begin
                st_next.pins     = drive_pins(1'b0, st.enabled, st.pins, emask);
                st_next.tsc      = '0;
                st_next.ev_phase = EV_OFF;
              end
              default: begin
                st_next.blinks_left = blinks_dec;
                do_restore = (blinks_dec == 8'd0);
                do_light   = (blinks_dec != 8'd0);
              end
            endcase
          end
        end else begin
          case (st.led_mode)
            LM_OFF: begin
              if (st.pins != 3'b000) begin
                st_next.pins = 3'b000;
                st_next.tsc  = '0;
              end
            end
            LM_ON: begin
              if (!lit) begin
                st_next.pins = drive_pins(1'b1, st.enabled, st.pins, amask);
                st_next.tsc  = '0;
              end
            end
            LM_BLINK: begin
              if (st.blink_interval == 32'd0) begin
                if (st.pins != 3'b000) begin
                  st_next.led_mode = LM_OFF;
                  st_next.pins     = 3'b000;
                  st_next.tsc      = '0;
                end
              end else if (tsc_inc >= st.blink_interval) begin
                st_next.pins = drive_pins(!lit, st.enabled, st.pins, amask);
                st_next.tsc  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_ENABLE: begin
        if (st.ev_phase == EV_IDLE) begin
          st_next.enabled = cmd.enable_value;
          if (!cmd.enable_value) begin
            st_next.pins = 3'b000;
            st_next.tsc  = '0;
          end
        end
      end
      OP_ON: begin
        if (st.ev_phase == EV_IDLE) begin
          st_next.pins         = drive_pins(1'b1, st.enabled, 3'b000, cmask);
          st_next.tsc          = '0;
          st_next.led_mode     = LM_ON;
          st_next.active_color = cmd.color;
        end
      end
      OP_OFF: begin
        if (st.ev_phase == EV_IDLE) begin
          st_next.pins     = 3'b000;
          st_next.tsc      = '0;
          st_next.led_mode = LM_OFF;
        end
      end
      OP_BLINK: begin
        if (st.ev_phase == EV_IDLE) begin
          st_next.blink_interval = cmd.interval;
          if (cmd.interval == 32'd0) begin
            st_next.led_mode = LM_OFF;
          end else begin
            st_next.led_mode     = LM_BLINK;
            st_next.active_color = cmd.color;
          end
        end
      end
      OP_EVENT: begin
        if (st.ev_phase == EV_IDLE) begin
          st_next.saved_pins  = st.pins;
          st_next.saved_mode  = st.led_mode;
          st_next.led_mode    = LM_EVENT;
          st_next.ev_color    = cmd.color;
          st_next.blinks_left = cmd.count;
          st_next.pins        = 3'b000;
          st_next.tsc         = '0;
          st_next.ev_phase    = EV_DARK;
          st_next.ev_timer    = '0;
        end
      end
      default: begin
      end
    endcase

    if (do_restore) begin
      st_next.pins     = st.saved_pins & {3{st.enabled}};
      st_next.tsc      = '0;
      st_next.led_mode = st.saved_mode;
      st_next.ev_phase = EV_IDLE;
      st_next.ev_timer = '0;
    end
    if (do_light) begin
      st_next.pins     = drive_pins(1'b1, st.enabled, st.pins, emask);
      st_next.tsc      = '0;
      st_next.ev_phase = EV_ON;
    end
  end

  assign res.red_pin      = st_next.pins[0];
  assign res.green_pin    = st_next.pins[1];
  assign res.blue_pin     = st_next.pins[2];
  assign res.current_mode = st_next.led_mode;

endmodule

/* src/rlbc_out_buf.sv */
// two-entry result buffer: output register plus skid register
// depends on rlbc_pkg
module rlbc_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlbc_pkg::res_t push_data,
  output logic           full,
  output logic           res_valid,
  input  logic           res_stall,
  output rlbc_pkg::res_t res
);
  import rlbc_pkg::*;

  logic skid_valid;
  res_t skid;
  logic out_take;
  logic out_load;

  assign out_take  = res_valid && !res_stall;
  assign out_load  = out_take || !res_valid;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      res_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= skid_valid ? skid : push_data;
    end
    if (push && !out_load) begin
      skid <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("beat pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_take) |=> (res_valid && !skid_valid))
    else $error("skid entry not moved to output");

endmodule

/* verif/rgb_led_mode_blink_controller_core_tb.sv */
// testbench for rgb_led_mode_blink_controller_core: random and directed command beats,
// a tracker class that predicts pins and mode, and checks every result beat in order
// depends on rlbc_pkg and the rgb_led_mode_blink_controller_core rtl
`timescale 1ns / 100ps

module rgb_led_mode_blink_controller_core_tb;
  import rlbc_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [2:0] COL_NONE  = 3'd7;
  localparam logic [2:0] ALL_PINS  = 3'b111;
  localparam int NPHASE = 6;

  class led_state_tracker;
    logic [15:0] phase_ticks;
    logic [2:0]  pins;
    logic        enabled;
    led_mode_t   led_mode;
    logic [2:0]  active_color;
    logic [31:0] blink_interval;
    logic [31:0] ticks_idle;
    logic [2:0]  saved_pins;
    led_mode_t   saved_mode;
    logic [15:0] ev_timer;
    logic [7:0]  blinks_left;
    ev_phase_t   ev_phase;
    logic [2:0]  ev_color;
    res_t        pins_due[$];
    int          errors;

    function new();
      phase_ticks    = PHASE_TICKS_RESET;
      pins           = '0;
      enabled        = 1'b0;
      led_mode       = LM_OFF;
      active_color   = COL_RED;
      blink_interval = '0;
      ticks_idle     = '0;
      saved_pins     = '0;
      saved_mode     = LM_OFF;
      ev_timer       = '0;
      blinks_left    = '0;
      ev_phase       = EV_IDLE;
      ev_color       = COL_RED;
      errors         = 0;
    endfunction

    function logic [2:0] color_pins(logic [2:0] color);
      logic [2:0] sel;
      case (color)
        COL_RED:     sel = 3'b001;
        COL_GREEN:   sel = 3'b010;
        COL_BLUE:    sel = 3'b100;
        COL_YELLOW:  sel = 3'b011;
        COL_MAGENTA: sel = 3'b101;
        COL_CYAN:    sel = 3'b110;
        COL_ALL:     sel = 3'b111;
        default:     sel = 3'b000;
      endcase
      return sel;
    endfunction

    function void set_pins(logic level, logic [2:0] sel);
      if (level && enabled) begin
        pins = pins | sel;
      end else begin
        pins = pins & ~sel;
      end
      ticks_idle = '0;
    endfunction

    function logic lit(logic [2:0] color);
      return (pins & color_pins(color)) != 3'b000;
    endfunction

    function void end_event();
      set_pins(saved_pins[0], 3'b001);
      set_pins(saved_pins[1], 3'b010);
      set_pins(saved_pins[2], 3'b100);
      led_mode = saved_mode;
      ev_phase = EV_IDLE;
      ev_timer = '0;
    endfunction

    function void event_step();
      ev_timer = ev_timer + 16'd1;
      if (ev_timer < phase_ticks) begin
        return;
      end
      ev_timer = '0;
      if (ev_phase == EV_ON) begin
        set_pins(1'b0, color_pins(ev_color));
        ev_phase = EV_OFF;
      end else begin
        if (ev_phase == EV_OFF) begin
          blinks_left = blinks_left - 8'd1;
        end
        if (blinks_left == 8'd0) begin
          end_event();
        end else begin
          set_pins(1'b1, color_pins(ev_color));
          ev_phase = EV_ON;
        end
      end
    endfunction

    function void mode_step();
      case (led_mode)
        LM_OFF: begin
          if (pins != 3'b000) set_pins(1'b0, ALL_PINS);
        end
        LM_ON: begin
          if (!lit(active_color)) set_pins(1'b1, color_pins(active_color));
        end
        LM_BLINK: begin
          if (blink_interval == '0) begin
            if (pins != 3'b000) begin
              led_mode = LM_OFF;
              set_pins(1'b0, ALL_PINS);
            end
          end else if (ticks_idle >= blink_interval) begin
            set_pins(!lit(active_color), color_pins(active_color));
          end
        end
        default: ;
      endcase
    endfunction

    function void take_cmd(cmd_t c);
      if (c.mode == OP_TICK) begin
        if (ticks_idle != '1) ticks_idle = ticks_idle + 32'd1;
        if (ev_phase != EV_IDLE) event_step();
        else mode_step();
      end else if (ev_phase == EV_IDLE) begin
        case (c.mode)
          OP_ENABLE: begin
            enabled = c.enable_value;
            if (!c.enable_value) set_pins(1'b0, ALL_PINS);
          end
          OP_ON: begin
            if (pins != 3'b000) set_pins(1'b0, ALL_PINS);
            set_pins(1'b1, color_pins(c.color));
            led_mode     = LM_ON;
            active_color = c.color;
          end
          OP_OFF: begin
            set_pins(1'b0, ALL_PINS);
            led_mode = LM_OFF;
          end
          OP_BLINK: begin
            blink_interval = c.interval;
            if (c.interval == '0) begin
              led_mode = LM_OFF;
            end else begin
              led_mode     = LM_BLINK;
              active_color = c.color;
            end
          end
          OP_EVENT: begin
            saved_pins  = pins;
            saved_mode  = led_mode;
            led_mode    = LM_EVENT;
            ev_color    = c.color;
            blinks_left = c.count;
            set_pins(1'b0, ALL_PINS);
            ev_phase    = EV_DARK;
            ev_timer    = '0;
          end
          default: ;
        endcase
      end
      pins_due.push_back('{red_pin: pins[0], green_pin: pins[1], blue_pin: pins[2],
                           current_mode: led_mode});
    endfunction

    function void check_pins(res_t got);
      res_t want;
      if (pins_due.size() == 0) begin
        $error("result beat with no command pending: %p", got);
        errors++;
        return;
      end
      want = pins_due.pop_front();
      if (got.red_pin !== want.red_pin) begin
        $error("red_pin: expected %0d, actual %0d", want.red_pin, got.red_pin);
        errors++;
      end
      if (got.green_pin !== want.green_pin) begin
        $error("green_pin: expected %0d, actual %0d", want.green_pin, got.green_pin);
        errors++;
      end
      if (got.blue_pin !== want.blue_pin) begin
        $error("blue_pin: expected %0d, actual %0d", want.blue_pin, got.blue_pin);
        errors++;
      end
      if (got.current_mode !== want.current_mode) begin
        $error("current_mode: expected %0d, actual %0d", want.current_mode, got.current_mode);
        errors++;
      end
    endfunction

    function int pending();
      return pins_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  led_state_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned max_count = 1;
  bit          hold_req = 1'b0;

  rgb_led_mode_blink_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: checks every accepted beat, stalls at random or for a long hold
  initial begin : result_sink
    int unsigned hold_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) tracker.check_pins(res);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left != 0) hold_left--;
      res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [2:0] color, logic [31:0] interval,
                                    logic [7:0] count, logic en);
    cmd_t c;
    c.mode         = op;
    c.color        = color;
    c.interval     = interval;
    c.count        = count;
    c.enable_value = en;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    c.mode         = OP_TICK;
    c.color        = 3'($urandom_range(7));
    c.interval     = $urandom;
    c.count        = 8'($urandom);
    c.enable_value = 1'($urandom_range(1));
    pick = $urandom_range(99);
    // keep an event moving with mostly ticks
    if (tracker.ev_phase != EV_IDLE && pick < 85) pick = 0;
    if (pick < 55) begin
      c.mode = OP_TICK;
    end else if (pick < 62) begin
      c.mode         = OP_ENABLE;
      c.enable_value = ($urandom_range(9) < 8);
    end else if (pick < 74) begin
      c.mode = OP_ON;
    end else if (pick < 79) begin
      c.mode = OP_OFF;
    end else if (pick < 93) begin
      c.mode = OP_BLINK;
      case ($urandom_range(9))
        0:       c.interval = '0;
        1:       c.interval = $urandom;
        2:       c.interval = 32'hFFFF_FFFF;
        default: c.interval = $urandom_range(1, 6);
      endcase
    end else if (pick < 97) begin
      c.mode  = OP_EVENT;
      c.count = ($urandom_range(9) == 0) ? 8'(max_count) : 8'($urandom_range(4));
      if (c.count > max_count) c.count = 8'(max_count);
    end else begin
      c.mode = (pick == 97) ? OP_SPARE6 : OP_SPARE7;
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    tracker.take_cmd(c);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_phase_ticks(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.phase_ticks = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_cmd(make_cmd(OP_TICK,   COL_RED,     32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_ON,     COL_RED,     32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_ENABLE, COL_RED,     32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_TICK,   COL_RED,     32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_ON,     COL_ALL,     32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_NONE,    32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_YELLOW,  32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_MAGENTA, 32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_CYAN,    32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_GREEN,   32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_ON,     COL_BLUE,    32'd0, 8'd0, 1'b1));
    // compound colour blinking with one pin already lit
    send_cmd(make_cmd(OP_BLINK,  COL_CYAN,    32'd1, 8'd0, 1'b1));
    repeat (3) send_cmd(make_cmd(OP_TICK, COL_RED, 32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_BLINK,  COL_RED,     32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_OFF,    COL_RED,     32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_BLINK,  COL_ALL,     32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_TICK,   COL_ALL,     32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_SPARE6, COL_ALL,     32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_SPARE7, COL_NONE,    32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_ENABLE, COL_RED,     32'd0, 8'd0, 1'b0));
    send_cmd(make_cmd(OP_ENABLE, COL_RED,     32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_EVENT,  COL_RED,     32'd0, 8'd0, 1'b1));
    // commands while an event runs are dropped
    send_cmd(make_cmd(OP_ON,     COL_GREEN,   32'd0, 8'd0, 1'b1));
    send_cmd(make_cmd(OP_EVENT,  COL_ALL,     32'd0, 8'hFF, 1'b1));
  endtask

  initial begin : stimulus
    int unsigned ticks_per_phase[NPHASE] = '{200, 0, 1, 65535, 3, 0};
    int unsigned items_per_phase[NPHASE] = '{200, 200, 200, 150, 250, 200};
    int unsigned count_limit[NPHASE]     = '{1, 255, 255, 0, 20, 8};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NPHASE; p++) begin
      if (p != 0) begin
        drain();
        write_phase_ticks((p == NPHASE - 1) ? 16'($urandom_range(2, 16))
                                            : 16'(ticks_per_phase[p]));
      end
      case (p / 2)
        0:       begin send_idle_pct = 23; recv_idle_pct = 83; end
        1:       begin send_idle_pct = 83; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      max_count = count_limit[p];
      if (p == 0) run_directed();
      if (p == 4) hold_req = 1'b1;
      repeat (items_per_phase[p]) send_cmd(random_cmd());
    end
    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/rlbc_pkg.sv
src/rlbc_step.sv
src/rlbc_out_buf.sv
src/rgb_led_mode_blink_controller_core.sv
verif/rgb_led_mode_blink_controller_core_tb.sv
